// ----- rtl/cmtcm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmtcm_pkg
// Shared widths, register indexes, reset values and controller/datapath
// command and status types of the multi-target latency monitor.
// ----------------------------------------------------------------------------
package cmtcm_pkg;

    localparam int LATENCY_W   = 32;
    localparam int SIZE_W      = 24;
    localparam int INTERVAL_W  = 32;
    localparam int COUNT_W     = 32;
    localparam int CFG_DATA_W  = 57;
    localparam int CFG_INDEX_W = 3;

    localparam int NUM_BANDS_DEFAULT = 4;
    localparam int BAND_REGS         = 4;
    localparam int BAND_VALID_BIT    = 56;
    localparam int BAND_BOUND_LSB    = 32;
    localparam int BAND_TARGET_W     = 32;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_INTERVAL = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_TARGET   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_NORMALIZE_MODE   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BAND_ENTRY_0     = 3'd3;

    localparam logic [INTERVAL_W-1:0] INITIAL_INTERVAL_RESET = 32'd100000000;
    localparam logic [LATENCY_W-1:0]  DEFAULT_TARGET_RESET   = 32'd5000000;
    localparam logic [INTERVAL_W-1:0] FALLBACK_INTERVAL      = 32'd1000;

    localparam int SQRT_STEPS  = COUNT_W / 2;
    localparam int DIV_STEPS   = INTERVAL_W;
    localparam int STEP_CNT_W  = $clog2(DIV_STEPS);
    localparam int ROOT_W      = SQRT_STEPS + 1;
    localparam int SQRT_REM_W  = SQRT_STEPS + 4;
    localparam int DIV_REM_W   = ROOT_W + 1;

    typedef struct packed {
        logic sample_we;
        logic judge;
        logic sqrt_step;
        logic round;
        logic div_step;
        logic finish;
    } cmtcm_cmd_t;

    typedef struct packed {
        logic viol;
        logic out_blocked;
    } cmtcm_status_t;

endpackage

// ----- rtl/cmtcm_sample_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmtcm_sample_if
// Input channel: latency samples and interval ticks.
// ----------------------------------------------------------------------------
interface cmtcm_sample_if;
    logic                             valid;
    logic                             ready;
    logic                             operation;
    logic [cmtcm_pkg::LATENCY_W-1:0]  sample_latency;
    logic [cmtcm_pkg::SIZE_W-1:0]     txn_size;

    modport source (output valid, output operation, output sample_latency,
                    output txn_size, input ready);
    modport sink   (input valid, input operation, input sample_latency,
                    input txn_size, output ready);
endinterface

// ----- rtl/cmtcm_result_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmtcm_result_if
// Output channel: one interval verdict per tick.
// ----------------------------------------------------------------------------
interface cmtcm_result_if;
    logic                              valid;
    logic                              ready;
    logic                              violation;
    logic [cmtcm_pkg::INTERVAL_W-1:0]  next_interval;
    logic [cmtcm_pkg::COUNT_W-1:0]     viol_streak;

    modport source (output valid, output violation, output next_interval,
                    output viol_streak, input ready);
    modport sink   (input valid, input violation, input next_interval,
                    input viol_streak, output ready);
endinterface

// ----- rtl/cmtcm_cfg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmtcm_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface cmtcm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [cmtcm_pkg::CFG_INDEX_W-1:0] index;
    logic [cmtcm_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/cmtcm_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmtcm_ctrl
// Sequencer: takes samples while idle, walks a tick through judge and, on a
// violation, square root, rounding and divide, then result hand-off.
// ----------------------------------------------------------------------------
module cmtcm_ctrl
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_operation,
    output logic                     in_ready,
    input  cmtcm_pkg::cmtcm_status_t status,
    output cmtcm_pkg::cmtcm_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_JUDGE,
        S_SQRT,
        S_ROUND,
        S_DIV,
        S_DONE
    } state_t;

    state_t                               state_reg;
    state_t                               state_next;
    logic [cmtcm_pkg::STEP_CNT_W-1:0]     cnt_reg;
    logic [cmtcm_pkg::STEP_CNT_W-1:0]     cnt_next;

    always_comb
    begin
        in_ready   = (state_reg == S_IDLE);
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.sample_we = in_valid && (in_operation == cmtcm_pkg::OP_SAMPLE);
                if (in_valid && (in_operation == cmtcm_pkg::OP_TICK))
                begin
                    state_next = S_JUDGE;
                end
            end
            S_JUDGE:
            begin
                cmd.judge = 1'b1;
                if (status.viol)
                begin
                    state_next = S_SQRT;
                    cnt_next   = cmtcm_pkg::STEP_CNT_W'(cmtcm_pkg::SQRT_STEPS - 1);
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_ROUND;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = S_DIV;
                cnt_next   = cmtcm_pkg::STEP_CNT_W'(cmtcm_pkg::DIV_STEPS - 1);
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_DONE:
            begin
                cmd.finish = !status.out_blocked;
                if (!status.out_blocked)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_sqrt_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQRT && cnt_reg != '0) |=> (state_reg == S_SQRT))
        else $error("square root left before its last step");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && status.out_blocked) |=> (state_reg == S_DONE))
        else $error("result dropped while output stalled");

endmodule

// ----- rtl/cmtcm_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmtcm_dp
// Datapath: configuration registers, band and global minimums, interval
// judge, bit-serial square root, restoring divider and result register.
// ----------------------------------------------------------------------------
module cmtcm_dp
#(
    parameter int NUM_BANDS = cmtcm_pkg::NUM_BANDS_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  cmtcm_pkg::cmtcm_cmd_t               cmd,
    output cmtcm_pkg::cmtcm_status_t            status,
    input  logic [cmtcm_pkg::LATENCY_W-1:0]     sample_latency,
    input  logic [cmtcm_pkg::SIZE_W-1:0]        txn_size,
    input  logic                                cfg_we,
    input  logic [cmtcm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cmtcm_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                res_ready,
    output logic                                res_valid,
    output logic                                res_violation,
    output logic [cmtcm_pkg::INTERVAL_W-1:0]    res_next_interval,
    output logic [cmtcm_pkg::COUNT_W-1:0]       res_viol_streak
);

    localparam int LAT_W  = cmtcm_pkg::LATENCY_W;
    localparam int SZ_W   = cmtcm_pkg::SIZE_W;
    localparam int TGT_W  = cmtcm_pkg::BAND_TARGET_W;
    localparam int CNT_W  = cmtcm_pkg::COUNT_W;
    localparam int IVL_W  = cmtcm_pkg::INTERVAL_W;
    localparam int ROOT_W = cmtcm_pkg::ROOT_W;
    localparam int SREM_W = cmtcm_pkg::SQRT_REM_W;
    localparam int DREM_W = cmtcm_pkg::DIV_REM_W;

    logic [IVL_W-1:0]  initial_interval_reg;
    logic [LAT_W-1:0]  default_target_reg;
    logic              normalize_mode_reg;
    logic [NUM_BANDS-1:0] band_valid_reg;
    logic [SZ_W-1:0]   band_bound_reg  [NUM_BANDS];
    logic [TGT_W-1:0]  band_target_reg [NUM_BANDS];

    logic [NUM_BANDS-1:0] bmin_valid_reg;
    logic [LAT_W-1:0]  bmin_value_reg [NUM_BANDS];
    logic              gmin_valid_reg;
    logic [LAT_W-1:0]  gmin_value_reg;
    logic [SZ_W-1:0]   gmin_size_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              viol_reg;

    logic [CNT_W-1:0]  sq_n_reg;
    logic [SREM_W-1:0] sq_rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [IVL_W-1:0]  dvd_reg;
    logic [DREM_W-1:0] div_rem_reg;

    logic              res_valid_reg;
    logic              res_violation_reg;
    logic [IVL_W-1:0]  res_next_interval_reg;
    logic [CNT_W-1:0]  res_count_reg;

    logic [NUM_BANDS-1:0] samp_hot;
    logic              samp_taken;
    logic              gmin_taken;
    logic [TGT_W-1:0]  gmin_target;
    logic              any_band;
    logic              band_viol;
    logic [LAT_W-1:0]  gmin_norm;
    logic              gmin_viol;
    logic              viol_c;

    logic [SREM_W-1:0] sq_rem_sh;
    logic [SREM_W-1:0] sq_trial;
    logic              sq_bit;
    logic [DREM_W-1:0] div_rem_sh;
    logic              div_bit;
    logic [IVL_W-1:0]  viol_interval;

    always_comb
    begin
        samp_hot    = '0;
        samp_taken  = 1'b0;
        gmin_taken  = 1'b0;
        gmin_target = default_target_reg;
        any_band    = 1'b0;
        band_viol   = 1'b0;
        for (int k = 0; k < NUM_BANDS; k++)
        begin
            if (band_valid_reg[k] && txn_size < band_bound_reg[k] && !samp_taken)
            begin
                samp_hot[k] = 1'b1;
                samp_taken  = 1'b1;
            end
            if (band_valid_reg[k] && gmin_size_reg < band_bound_reg[k] && !gmin_taken)
            begin
                gmin_taken  = 1'b1;
                gmin_target = band_target_reg[k];
            end
            if (band_valid_reg[k] && bmin_valid_reg[k])
            begin
                any_band = 1'b1;
                if (bmin_value_reg[k] > band_target_reg[k])
                begin
                    band_viol = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        gmin_norm = (gmin_value_reg > gmin_target) ? (gmin_value_reg - gmin_target)
                                                   : gmin_value_reg;
        gmin_viol = normalize_mode_reg ? (gmin_norm > default_target_reg)
                                       : (gmin_value_reg > gmin_target);
        if (!normalize_mode_reg && any_band)
        begin
            viol_c = band_viol;
        end
        else
        begin
            viol_c = gmin_valid_reg && gmin_viol;
        end
        if (viol_c)
        begin
            count_next = (count_reg == '1) ? count_reg : count_reg + 1'b1;
        end
        else
        begin
            count_next = '0;
        end
    end

    always_comb
    begin
        sq_rem_sh  = {sq_rem_reg[SREM_W-3:0], sq_n_reg[CNT_W-1 -: 2]};
        sq_trial   = SREM_W'({root_reg, 2'b01});
        sq_bit     = (sq_rem_sh >= sq_trial);
        div_rem_sh = {div_rem_reg[DREM_W-2:0], dvd_reg[IVL_W-1]};
        div_bit    = (div_rem_sh >= DREM_W'(root_reg));
        viol_interval = (root_reg == '0 || dvd_reg == '0) ? cmtcm_pkg::FALLBACK_INTERVAL
                                                           : dvd_reg;
    end

    assign status.viol        = viol_c;
    assign status.out_blocked = res_valid_reg && !res_ready;

    // configuration, running minimums, violation count and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_interval_reg <= cmtcm_pkg::INITIAL_INTERVAL_RESET;
            default_target_reg   <= cmtcm_pkg::DEFAULT_TARGET_RESET;
            normalize_mode_reg   <= 1'b0;
            band_valid_reg       <= '0;
            bmin_valid_reg       <= '0;
            gmin_valid_reg       <= 1'b0;
            gmin_size_reg        <= '0;
            count_reg            <= '0;
            viol_reg             <= 1'b0;
            res_valid_reg        <= 1'b0;
            for (int k = 0; k < NUM_BANDS; k++)
            begin
                band_bound_reg[k]  <= '0;
                band_target_reg[k] <= '0;
            end
        end
        else
        begin
            if (cmd.sample_we)
            begin
                if (!normalize_mode_reg && samp_taken)
                begin
                    for (int k = 0; k < NUM_BANDS; k++)
                    begin
                        if (samp_hot[k] &&
                            (!bmin_valid_reg[k] || sample_latency < bmin_value_reg[k]))
                        begin
                            bmin_valid_reg[k] <= 1'b1;
                        end
                    end
                end
                else if (!gmin_valid_reg || sample_latency < gmin_value_reg)
                begin
                    gmin_valid_reg <= 1'b1;
                    gmin_size_reg  <= txn_size;
                end
            end
            if (cmd.judge)
            begin
                viol_reg       <= viol_c;
                count_reg      <= count_next;
                gmin_valid_reg <= 1'b0;
                gmin_size_reg  <= '0;
            end
            if (cmd.finish)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    cmtcm_pkg::CFG_INITIAL_INTERVAL:
                        initial_interval_reg <= cfg_data[IVL_W-1:0];
                    cmtcm_pkg::CFG_DEFAULT_TARGET:
                        default_target_reg <= cfg_data[LAT_W-1:0];
                    cmtcm_pkg::CFG_NORMALIZE_MODE:
                        normalize_mode_reg <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
                for (int k = 0; k < NUM_BANDS; k++)
                begin
                    if (k < cmtcm_pkg::BAND_REGS &&
                        cfg_index == cmtcm_pkg::CFG_INDEX_W'(cmtcm_pkg::CFG_BAND_ENTRY_0 + k))
                    begin
                        band_valid_reg[k]  <= cfg_data[cmtcm_pkg::BAND_VALID_BIT];
                        band_bound_reg[k]  <= cfg_data[cmtcm_pkg::BAND_BOUND_LSB +: SZ_W];
                        band_target_reg[k] <= cfg_data[TGT_W-1:0];
                        bmin_valid_reg[k]  <= 1'b0;
                    end
                end
            end
        end
    end

    // minimum values, square root, divider and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.sample_we)
        begin
            if (!normalize_mode_reg && samp_taken)
            begin
                for (int k = 0; k < NUM_BANDS; k++)
                begin
                    if (samp_hot[k] &&
                        (!bmin_valid_reg[k] || sample_latency < bmin_value_reg[k]))
                    begin
                        bmin_value_reg[k] <= sample_latency;
                    end
                end
            end
            else if (!gmin_valid_reg || sample_latency < gmin_value_reg)
            begin
                gmin_value_reg <= sample_latency;
            end
        end
        if (cmd.judge)
        begin
            sq_n_reg   <= count_next;
            sq_rem_reg <= '0;
            root_reg   <= '0;
        end
        if (cmd.sqrt_step)
        begin
            sq_n_reg   <= {sq_n_reg[CNT_W-3:0], 2'b00};
            sq_rem_reg <= sq_bit ? (sq_rem_sh - sq_trial) : sq_rem_sh;
            root_reg   <= {root_reg[ROOT_W-2:0], sq_bit};
        end
        if (cmd.round)
        begin
            root_reg    <= (sq_rem_reg > SREM_W'(root_reg)) ? root_reg + 1'b1 : root_reg;
            dvd_reg     <= initial_interval_reg;
            div_rem_reg <= '0;
        end
        if (cmd.div_step)
        begin
            div_rem_reg <= div_bit ? (div_rem_sh - DREM_W'(root_reg)) : div_rem_sh;
            dvd_reg     <= {dvd_reg[IVL_W-2:0], div_bit};
        end
        if (cmd.finish)
        begin
            res_violation_reg     <= viol_reg;
            res_next_interval_reg <= viol_reg ? viol_interval : initial_interval_reg;
            res_count_reg         <= count_reg;
        end
    end

    assign res_valid         = res_valid_reg;
    assign res_violation     = res_violation_reg;
    assign res_next_interval = res_next_interval_reg;
    assign res_viol_streak   = res_count_reg;

    a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.judge && !viol_c) |=> (count_reg == '0))
        else $error("count not cleared after a clean interval");

    a_gmin_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.judge |=> !gmin_valid_reg)
        else $error("global minimum survived a tick");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> res_valid_reg)
        else $error("finished tick produced no result");

endmodule

// ----- rtl/multi_target_codel_monitor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_target_codel_monitor
// Minimum-latency monitor with size-banded targets and interval control.
// ----------------------------------------------------------------------------
// Channels: sample (operation, sample_latency, txn_size) in, result
// (violation, next_interval, viol_streak) out, cfg (index, data) for
// register writes; every transaction completes when valid and ready are high.
// A latency sample is taken while idle and yields no result; samples are
// accepted back to back. A tick yields one result; without a violation it goes
// from judge straight to hand-off, with one it also runs the 16-step square
// root and the 32-step divider, sharing the datapath, before the result is
// registered.
// Input ready is low while a tick is in flight.
// A finished result waits in an output register; samples keep flowing while
// it is stalled, and a following tick holds in its last step until the
// receiver takes the earlier result.
// Reset restores register defaults and empties all minimums and the count.
// cfg is always ready; write it only while the block is idle.
// ----------------------------------------------------------------------------
module multi_target_codel_monitor
#(
    parameter int NUM_BANDS = cmtcm_pkg::NUM_BANDS_DEFAULT
)
(
    input  logic           clk,
    input  logic           rst_n,
    cmtcm_cfg_if.sink      cfg,
    cmtcm_sample_if.sink   sample,
    cmtcm_result_if.source result
);

    cmtcm_pkg::cmtcm_cmd_t    cmd;
    cmtcm_pkg::cmtcm_status_t status;
    logic                     cfg_we;

    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;

    cmtcm_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (sample.valid),
        .in_operation (sample.operation),
        .in_ready     (sample.ready),
        .status       (status),
        .cmd          (cmd)
    );

    cmtcm_dp
    #(
        .NUM_BANDS (NUM_BANDS)
    )
    u_dp
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .sample_latency    (sample.sample_latency),
        .txn_size          (sample.txn_size),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg.index),
        .cfg_data          (cfg.data),
        .res_ready         (result.ready),
        .res_valid         (result.valid),
        .res_violation     (result.violation),
        .res_next_interval (result.next_interval),
        .res_viol_streak   (result.viol_streak)
    );

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multi-target latency monitor. A built-in
// predictor tracks band and global minimums, judges every interval tick and
// queues the expected verdict; a checker compares each result transaction
// against the oldest queued verdict. Directed cases cover defaults, band
// selection and rewrite, zero and maximum intervals, normalize mode and an
// unused register index. Random phases follow under varied register settings,
// bursty input traffic, output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LAT_W   = cmtcm_pkg::LATENCY_W;
    localparam int SZ_W    = cmtcm_pkg::SIZE_W;
    localparam int IVL_W   = cmtcm_pkg::INTERVAL_W;
    localparam int CNT_W   = cmtcm_pkg::COUNT_W;
    localparam int IDX_W   = cmtcm_pkg::CFG_INDEX_W;
    localparam int DATA_W  = cmtcm_pkg::CFG_DATA_W;
    localparam int BANDS   = cmtcm_pkg::NUM_BANDS_DEFAULT;
    localparam logic [IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int SETTLE_CYCLES = 60;

    typedef struct {
        logic             violation;
        logic [IVL_W-1:0] next_interval;
        logic [CNT_W-1:0] viol_streak;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    cmtcm_cfg_if    cfg_bus ();
    cmtcm_sample_if sample_bus ();
    cmtcm_result_if result_bus ();

    multi_target_codel_monitor i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .sample (sample_bus),
        .result (result_bus)
    );

    logic [IVL_W-1:0] base_interval = cmtcm_pkg::INITIAL_INTERVAL_RESET;
    logic [LAT_W-1:0] dflt_target   = cmtcm_pkg::DEFAULT_TARGET_RESET;
    logic             norm_mode     = 1'b0;
    logic             band_on     [BANDS] = '{default: 1'b0};
    logic [SZ_W-1:0]  band_bound  [BANDS] = '{default: '0};
    logic [LAT_W-1:0] band_target [BANDS] = '{default: '0};
    logic             bmin_ok     [BANDS] = '{default: 1'b0};
    logic [LAT_W-1:0] bmin        [BANDS] = '{default: '0};
    logic             gmin_ok   = 1'b0;
    logic [LAT_W-1:0] gmin      = '0;
    logic [SZ_W-1:0]  gmin_size = '0;
    logic [CNT_W-1:0] viol_count = '0;
    logic [IVL_W-1:0] cur_interval = cmtcm_pkg::INITIAL_INTERVAL_RESET;

    verdict_t verdict_q [$];
    int error_count = 0;
    int rx_hold = 0;
    int rx_span = 0;
    int rx_mode = 0;
    int burst_left = 0;

    always #10 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int find_band(logic [SZ_W-1:0] size);
        for (int k = 0; k < BANDS; k++)
        begin
            if (band_on[k] && size < band_bound[k])
                return k;
        end
        return -1;
    endfunction

    function automatic void apply_config(logic [IDX_W-1:0] index,
                                         logic [DATA_W-1:0] data);
        int k;
        k = int'(index) - int'(cmtcm_pkg::CFG_BAND_ENTRY_0);
        case (index)
            cmtcm_pkg::CFG_INITIAL_INTERVAL: base_interval = data[IVL_W-1:0];
            cmtcm_pkg::CFG_DEFAULT_TARGET:   dflt_target = data[LAT_W-1:0];
            cmtcm_pkg::CFG_NORMALIZE_MODE:   norm_mode = data[0];
            default:
            begin
                if (k >= 0 && k < cmtcm_pkg::BAND_REGS && k < BANDS)
                begin
                    band_on[k]     = data[cmtcm_pkg::BAND_VALID_BIT];
                    band_bound[k]  = data[cmtcm_pkg::BAND_VALID_BIT-1:
                                          cmtcm_pkg::BAND_BOUND_LSB];
                    band_target[k] = data[cmtcm_pkg::BAND_TARGET_W-1:0];
                    bmin_ok[k]     = 1'b0;
                    bmin[k]        = '0;
                end
            end
        endcase
    endfunction

    function automatic void record_sample(logic [LAT_W-1:0] lat,
                                          logic [SZ_W-1:0] size);
        int k;
        k = norm_mode ? -1 : find_band(size);
        if (k >= 0)
        begin
            if (!bmin_ok[k] || lat < bmin[k])
            begin
                bmin_ok[k] = 1'b1;
                bmin[k]    = lat;
            end
        end
        else if (!gmin_ok || lat < gmin)
        begin
            gmin_ok   = 1'b1;
            gmin      = lat;
            gmin_size = size;
        end
    endfunction

    function automatic void predict_tick();
        logic             viol;
        logic             band_seen;
        logic [LAT_W-1:0] target;
        logic [LAT_W-1:0] excess;
        logic [31:0]      root;
        logic [63:0]      trial;
        int               k;
        viol      = 1'b0;
        band_seen = 1'b0;
        if (!norm_mode)
        begin
            for (int b = 0; b < BANDS; b++)
            begin
                if (band_on[b] && bmin_ok[b])
                begin
                    band_seen = 1'b1;
                    if (bmin[b] > band_target[b])
                        viol = 1'b1;
                end
            end
        end
        if (!band_seen && gmin_ok)
        begin
            target = dflt_target;
            k = find_band(gmin_size);
            if (k >= 0)
                target = band_target[k];
            if (norm_mode)
            begin
                excess = (gmin > target) ? gmin - target : gmin;
                viol = excess > dflt_target;
            end
            else
                viol = gmin > target;
        end
        if (viol)
        begin
            if (viol_count != '1)
                viol_count = viol_count + 1'b1;
            root = '0;
            for (int b = 15; b >= 0; b--)
            begin
                trial = 64'(root | (32'd1 << b));
                if (trial * trial <= 64'(viol_count))
                    root = root | (32'd1 << b);
            end
            if (64'(viol_count) > 64'(root) * 64'(root) + 64'(root))
                root = root + 1'b1;
            cur_interval = (root != 0) ? base_interval / root : '0;
            if (cur_interval == '0)
                cur_interval = cmtcm_pkg::FALLBACK_INTERVAL;
        end
        else
        begin
            viol_count   = '0;
            cur_interval = base_interval;
        end
        gmin_ok   = 1'b0;
        gmin      = '0;
        gmin_size = '0;
        verdict_q.push_back('{viol, cur_interval, viol_count});
    endfunction

    function automatic logic [DATA_W-1:0] band_word(logic valid,
                                                    logic [SZ_W-1:0] bound,
                                                    logic [LAT_W-1:0] target);
        return {valid, bound, target};
    endfunction

    function automatic logic [LAT_W-1:0] pick_latency();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return $urandom;
            default: return $urandom_range(0, 20000);
        endcase
    endfunction

    function automatic logic [SZ_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return SZ_W'($urandom);
            default: return SZ_W'($urandom_range(0, 5000));
        endcase
    endfunction

    always @(posedge clk)
    begin
        verdict_t exp_v;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (verdict_q.size() == 0)
            begin
                $display("%0t: unexpected result, violation %0d interval %0d streak %0d",
                         $time, result_bus.violation, result_bus.next_interval,
                         result_bus.viol_streak);
                error_count++;
            end
            else
            begin
                exp_v = verdict_q.pop_front();
                if (result_bus.violation !== exp_v.violation)
                begin
                    $display("%0t: violation mismatch, expected %0d actual %0d",
                             $time, exp_v.violation, result_bus.violation);
                    error_count++;
                end
                if (result_bus.next_interval !== exp_v.next_interval)
                begin
                    $display("%0t: next_interval mismatch, expected %0d actual %0d",
                             $time, exp_v.next_interval, result_bus.next_interval);
                    error_count++;
                end
                if (result_bus.viol_streak !== exp_v.viol_streak)
                begin
                    $display("%0t: viol_streak mismatch, expected %0d actual %0d",
                             $time, exp_v.viol_streak, result_bus.viol_streak);
                    error_count++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            result_bus.ready = 1'b0;
            rx_hold--;
        end
        else
        begin
            if (rx_span == 0)
            begin
                rx_mode = $urandom_range(0, 2);
                rx_span = $urandom_range(20, 200);
            end
            rx_span--;
            case (rx_mode)
                0:       result_bus.ready = 1'b1;
                1:       result_bus.ready = ($urandom_range(0, 1) == 1);
                default: result_bus.ready = ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic send_item(input logic op, input logic [LAT_W-1:0] lat,
                             input logic [SZ_W-1:0] size);
        @(negedge clk);
        sample_bus.valid          = 1'b1;
        sample_bus.operation      = op;
        sample_bus.sample_latency = lat;
        sample_bus.txn_size       = size;
        do
            @(posedge clk);
        while (!sample_bus.ready);
        if (op == cmtcm_pkg::OP_TICK)
            predict_tick();
        else
            record_sample(lat, size);
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(1, 12);
            @(negedge clk);
            sample_bus.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        else
            burst_left--;
    endtask

    task automatic settle();
        @(negedge clk);
        sample_bus.valid = 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [IDX_W-1:0] index,
                             input logic [DATA_W-1:0] data);
        @(negedge clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = index;
        cfg_bus.data  = data;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        apply_config(index, data);
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    task automatic test_defaults();
        send_item(cmtcm_pkg::OP_TICK, '0, '0);
        send_item(cmtcm_pkg::OP_SAMPLE, '1, '1);
        send_item(cmtcm_pkg::OP_SAMPLE, 32'd6000000, '0);
        send_item(cmtcm_pkg::OP_TICK, '1, '1);
        send_item(cmtcm_pkg::OP_SAMPLE, '0, 24'h123456);
        send_item(cmtcm_pkg::OP_TICK, '0, '0);
        settle();
    endtask

    task automatic test_band_targets();
        cfg_write(cmtcm_pkg::CFG_INITIAL_INTERVAL, '0);
        cfg_write(cmtcm_pkg::CFG_BAND_ENTRY_0, band_word(1'b1, 24'd100, 32'd1000));
        cfg_write(cmtcm_pkg::CFG_BAND_ENTRY_0 + 3'd1, band_word(1'b0, 24'd500, 32'd0));
        cfg_write(cmtcm_pkg::CFG_BAND_ENTRY_0 + 3'd2, band_word(1'b1, 24'd50, 32'd10));
        cfg_write(cmtcm_pkg::CFG_BAND_ENTRY_0 + 3'd3, band_word(1'b1, '1, '1));
        send_item(cmtcm_pkg::OP_SAMPLE, 32'd2000, 24'd10);
        send_item(cmtcm_pkg::OP_SAMPLE, 32'd3000, 24'd99);
        send_item(cmtcm_pkg::OP_SAMPLE, '1, 24'd300);
        send_item(cmtcm_pkg::OP_TICK, '0, '0);
        send_item(cmtcm_pkg::OP_TICK, '0, '0);
        send_item(cmtcm_pkg::OP_SAMPLE, '1, '1);
        settle();
        cfg_write(cmtcm_pkg::CFG_BAND_ENTRY_0, band_word(1'b1, 24'd100, 32'd1000));
        send_item(cmtcm_pkg::OP_TICK, '0, '0);
        send_item(cmtcm_pkg::OP_SAMPLE, 32'd6000000, '1);
        settle();
        cfg_write(cmtcm_pkg::CFG_BAND_ENTRY_0 + 3'd3, band_word(1'b1, '1, '1));
        send_item(cmtcm_pkg::OP_TICK, '0, '0);
        settle();
    endtask

    task automatic test_normalize();
        cfg_write(cmtcm_pkg::CFG_NORMALIZE_MODE, 57'd1);
        cfg_write(cmtcm_pkg::CFG_DEFAULT_TARGET, 57'd100);
        cfg_write(cmtcm_pkg::CFG_INITIAL_INTERVAL, 57'hFFFFFFFF);
        send_item(cmtcm_pkg::OP_SAMPLE, 32'd150, 24'd10);
        send_item(cmtcm_pkg::OP_TICK, '0, '0);
        send_item(cmtcm_pkg::OP_SAMPLE, 32'd1100, 24'd10);
        send_item(cmtcm_pkg::OP_TICK, '0, '0);
        send_item(cmtcm_pkg::OP_SAMPLE, 32'd1101, '1);
        send_item(cmtcm_pkg::OP_TICK, '0, '0);
        settle();
        cfg_write(CFG_UNUSED, '1);
        send_item(cmtcm_pkg::OP_TICK, '0, '0);
        settle();
    endtask

    task automatic random_config(input int phase);
        logic [63:0]      raw;
        logic [SZ_W-1:0]  bound;
        logic [LAT_W-1:0] target;
        int               n_valid;
        raw = {$urandom, $urandom};
        case (phase)
            0:
            begin
                cfg_write(cmtcm_pkg::CFG_INITIAL_INTERVAL, 57'hFFFFFFFF);
                cfg_write(cmtcm_pkg::CFG_DEFAULT_TARGET, '0);
            end
            1:
            begin
                cfg_write(cmtcm_pkg::CFG_INITIAL_INTERVAL, 57'd1);
                cfg_write(cmtcm_pkg::CFG_DEFAULT_TARGET, 57'hFFFFFFFF);
            end
            default:
            begin
                cfg_write(cmtcm_pkg::CFG_INITIAL_INTERVAL,
                          ($urandom_range(0, 1) == 0) ? 57'($urandom_range(1, 5000))
                                                      : 57'($urandom | 1));
                cfg_write(cmtcm_pkg::CFG_DEFAULT_TARGET,
                          ($urandom_range(0, 2) == 0) ? 57'($urandom)
                                                      : 57'($urandom_range(0, 20000)));
            end
        endcase
        raw[0] = ($urandom_range(0, 2) == 0);
        cfg_write(cmtcm_pkg::CFG_NORMALIZE_MODE, raw[DATA_W-1:0]);
        n_valid = $urandom_range(0, cmtcm_pkg::BAND_REGS);
        bound = '0;
        for (int k = 0; k < cmtcm_pkg::BAND_REGS; k++)
        begin
            raw = {$urandom, $urandom};
            bound = bound + SZ_W'($urandom_range(1, 2000));
            case ($urandom_range(0, 5))
                0:       target = '1;
                1:       target = '0;
                default: target = $urandom_range(0, 20000);
            endcase
            if ($urandom_range(0, 4) == 0)
                cfg_write(cmtcm_pkg::CFG_BAND_ENTRY_0 + 3'(k), raw[DATA_W-1:0]);
            else
                cfg_write(cmtcm_pkg::CFG_BAND_ENTRY_0 + 3'(k),
                          band_word(k < n_valid, bound, target));
        end
        if ($urandom_range(0, 3) == 0)
            cfg_write(CFG_UNUSED, raw[DATA_W-1:0]);
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 8; phase++)
        begin
            random_config(phase);
            for (int i = 0; i < 100; i++)
            begin
                if ($urandom_range(0, 5) == 0)
                    send_item(cmtcm_pkg::OP_TICK, $urandom, SZ_W'($urandom));
                else
                    send_item(cmtcm_pkg::OP_SAMPLE, pick_latency(), pick_size());
                pace_sender();
                if ($urandom_range(0, 60) == 0)
                    settle();
            end
            settle();
        end
    endtask

    task automatic test_backpressure();
        rx_hold = 400;
        for (int i = 0; i < 40; i++)
        begin
            if (i % 3 == 2)
                send_item(cmtcm_pkg::OP_TICK, $urandom, SZ_W'($urandom));
            else
                send_item(cmtcm_pkg::OP_SAMPLE, pick_latency(), pick_size());
        end
        settle();
    endtask

    initial
    begin
        cfg_bus.valid             = 1'b0;
        cfg_bus.index             = '0;
        cfg_bus.data              = '0;
        sample_bus.valid          = 1'b0;
        sample_bus.operation      = cmtcm_pkg::OP_SAMPLE;
        sample_bus.sample_latency = '0;
        sample_bus.txn_size       = '0;
        result_bus.ready          = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        test_defaults();
        test_band_targets();
        test_normalize();
        test_random_traffic();
        test_backpressure();

        settle();
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- multi_target_codel_monitor.f -----
rtl/cmtcm_pkg.sv
rtl/cmtcm_sample_if.sv
rtl/cmtcm_result_if.sv
rtl/cmtcm_cfg_if.sv
rtl/cmtcm_ctrl.sv
rtl/cmtcm_dp.sv
rtl/multi_target_codel_monitor.sv
sim/testbench.sv
